@@ src/xild_pkg.sv @@
package xild_pkg;

  // opcode flag bits
  localparam logic [7:0] FM = 8'h01;
  localparam logic [7:0] FB = 8'h02;
  localparam logic [7:0] FW = 8'h04;
  localparam logic [7:0] FP = 8'h08;
  localparam logic [7:0] FX = 8'h10;

  localparam logic [7:0] OP_ESC  = 8'h0F;
  localparam logic [7:0] PFX_OPS = 8'h66;
  localparam logic [7:0] PFX_ADR = 8'h67;
  localparam logic [7:0] OP_F6   = 8'hF6;
  localparam logic [7:0] OP_F7   = 8'hF7;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_EXT   = 3'd1,
    PH_FPU   = 3'd2,
    PH_MODRM = 3'd3,
    PH_SIB   = 3'd4,
    PH_SKIP  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] code_byte;
  } in_word_t;

  typedef struct packed {
    logic [4:0] instr_length;
    logic [4:0] opcode_offset;
    logic       prefix_overflow;
  } out_word_t;

  function automatic logic is_prefix(input logic [7:0] b);
    case (b)
      8'h2E, 8'h3E, 8'h36, 8'h26, 8'h64, 8'h65,
      8'hF0, 8'hF2, 8'hF3, 8'h66, 8'h67: is_prefix = 1'b1;
      default: is_prefix = 1'b0;
    endcase
  endfunction

  // one-byte opcode flags, by row of sixteen
  function automatic logic [7:0] one_byte_flags(input logic [7:0] b);
    logic [3:0] lo;
    logic [7:0] f;
    lo = b[3:0];
    f = 8'h00;
    case (b[7:4])
      4'h0, 4'h1, 4'h2, 4'h3: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h3, 4'h8, 4'h9, 4'hA, 4'hB: f = FM;
          4'h4, 4'hC: f = FB;
          4'h5, 4'hD: f = FP;
          default: f = 8'h00;
        endcase
      end
      4'h6: begin
        case (lo)
          4'h2, 4'h3: f = FM;
          4'h8: f = FP;
          4'h9: f = FM | FP;
          4'hA: f = FB;
          4'hB: f = FM | FB;
          default: f = 8'h00;
        endcase
      end
      4'h7: f = FB;
      4'h8: begin
        case (lo)
          4'h0, 4'h2, 4'h3: f = FM | FB;
          4'h1: f = FM | FP;
          default: f = FM;
        endcase
      end
      4'h9: f = (lo == 4'hA) ? (FW | FP) : 8'h00;
      4'hA: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h3, 4'h9: f = FP;
          4'h8: f = FB;
          default: f = 8'h00;
        endcase
      end
      4'hB: f = lo[3] ? FP : FB;
      4'hC: begin
        case (lo)
          4'h0, 4'h1, 4'h6: f = FM | FB;
          4'h2, 4'hA: f = FW;
          4'h4, 4'h5: f = FM;
          4'h7: f = FM | FP;
          4'h8: f = FB | FW;
          4'hD: f = FB;
          default: f = 8'h00;
        endcase
      end
      4'hD: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h3: f = FM;
          4'h4, 4'h5: f = FB;
          4'h6, 4'h7: f = 8'h00;
          default: f = FX;
        endcase
      end
      4'hE: begin
        case (lo)
          4'h8, 4'h9: f = FP;
          4'hA: f = FW | FP;
          4'hB: f = FB;
          default: f = lo[3] ? 8'h00 : FB;
        endcase
      end
      4'hF: f = (lo == 4'h6 || lo == 4'h7 || lo == 4'hE || lo == 4'hF) ? FM : 8'h00;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  // flags for the byte after the 0x0f escape
  function automatic logic [7:0] two_byte_flags(input logic [7:0] b);
    logic [3:0] lo;
    logic [7:0] f;
    lo = b[3:0];
    f = 8'h00;
    case (b[7:4])
      4'h0: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h3, 4'hD: f = FM;
          4'hF: f = FM | FB;
          default: f = 8'h00;
        endcase
      end
      4'h1: f = (lo <= 4'h8) ? FM : 8'h00;
      4'h2: f = (lo == 4'h5 || lo == 4'h7) ? 8'h00 : FM;
      4'h3: f = 8'h00;
      4'h4, 4'h5, 4'h6, 4'h9, 4'hD, 4'hE: f = FM;
      4'h7: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h3: f = FM | FB;
          4'h4, 4'h5, 4'h6, 4'hC, 4'hD, 4'hE, 4'hF: f = FM;
          default: f = 8'h00;
        endcase
      end
      4'h8: f = FP;
      4'hA: begin
        case (lo)
          4'h3, 4'h5, 4'hB, 4'hD, 4'hE, 4'hF: f = FM;
          4'h4, 4'hC: f = FM | FB;
          default: f = 8'h00;
        endcase
      end
      4'hB: begin
        case (lo)
          4'h8, 4'h9: f = 8'h00;
          4'hA: f = FM | FB;
          default: f = FM;
        endcase
      end
      4'hC: begin
        case (lo)
          4'h0, 4'h1, 4'h3, 4'h7: f = FM;
          4'h2, 4'h4, 4'h5, 4'h6: f = FM | FB;
          default: f = 8'h00;
        endcase
      end
      4'hF: f = (lo == 4'hF) ? 8'h00 : FM;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

@@ src/xild_if.sv @@
interface xild_in_if;
  logic                valid;
  logic                ready;
  xild_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface xild_out_if;
  logic                valid;
  logic                ready;
  xild_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/x86_instruction_length_decoder.sv @@
// x86 32-bit instruction length decoder. Takes one code byte per cycle on
// in_i and follows each instruction's layout (prefixes, opcode or 0x0f escape,
// fpu byte, modrm, sib, displacement and immediate). On an instruction's last
// byte it sends one word on out_o with the length and the opcode offset; more
// than MAX_PREFIXES prefixes gives a word with length 0 and prefix_overflow
// set. Each byte is decoded in the cycle it is accepted by a small table
// lookup and phase update; the result sits in a one-entry output register
// with a skid stage, so a byte is accepted every cycle unless the output is
// stalled with both stages full.
module x86_instruction_length_decoder #(
  parameter int MAX_PREFIXES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  xild_in_if.sink    in_i,
  xild_out_if.source out_o
);
  import xild_pkg::*;

  phase_e     phase_q, phase_d;
  logic [4:0] pcount_q, pcount_d;
  logic       osz_q, osz_d, asz_q, asz_d;
  logic [7:0] popc_q, popc_d, flags_q, flags_d;
  logic [1:0] mmode_q, mmode_d;
  logic [4:0] nbytes_q, nbytes_d;
  logic [3:0] skip_q, skip_d;

  logic       emit;
  out_word_t  res;

  // output register plus skid stage
  logic       ov_q, sv_q;
  out_word_t  od_q, sd_q;
  logic       fire;

  assign in_i.ready  = !sv_q;
  assign fire        = in_i.valid && in_i.ready;
  assign out_o.valid = ov_q;
  assign out_o.data  = od_q;

  // decode one byte
  always_comb begin
    logic [7:0] b;
    logic [4:0] nb;
    logic [4:0] pc;
    logic [3:0] imm;
    logic [3:0] disp;
    logic [3:0] tl;
    logic       do_tail;
    b = in_i.data.code_byte;
    nb = nbytes_q + 5'd1;
    phase_d = phase_q;
    pcount_d = pcount_q;
    osz_d = osz_q;
    asz_d = asz_q;
    popc_d = popc_q;
    flags_d = flags_q;
    mmode_d = mmode_q;
    nbytes_d = nb;
    skip_d = skip_q;
    emit = 1'b0;
    res = '0;
    pc = pcount_q + 5'd1;
    imm = 4'd0;
    disp = 4'd0;
    do_tail = 1'b0;
    case (phase_q)
      PH_EXT: begin
        flags_d = two_byte_flags(b);
        if ((flags_d & FX) != 0) phase_d = PH_FPU;
        else if ((flags_d & FM) != 0) phase_d = PH_MODRM;
        else do_tail = 1'b1;
      end
      PH_FPU: begin
        if ((flags_q & FM) != 0) phase_d = PH_MODRM;
        else do_tail = 1'b1;
      end
      PH_MODRM: begin
        if (popc_q == OP_F6 && b[5:3] == 3'd0) flags_d = flags_q | FB;
        if (popc_q == OP_F7 && b[5:3] == 3'd0) flags_d = flags_q | FP;
        case (b[7:6])
          2'd0: begin
            if (asz_q && b[2:0] == 3'd6) disp = 4'd2;
            if (!asz_q && b[2:0] == 3'd5) disp = 4'd4;
          end
          2'd1: disp = 4'd1;
          2'd2: disp = asz_q ? 4'd2 : 4'd4;
          default: disp = 4'd0;
        endcase
        if (b[7:6] != 2'd3 && !asz_q && b[2:0] == 3'd4) begin
          mmode_d = b[7:6];
          phase_d = PH_SIB;
        end else begin
          do_tail = 1'b1;
        end
      end
      PH_SIB: begin
        if (mmode_q == 2'd1) disp = 4'd1;
        else if (mmode_q == 2'd2) disp = 4'd4;
        else disp = (b[2:0] == 3'd5) ? 4'd4 : 4'd0;
        do_tail = 1'b1;
      end
      PH_SKIP: begin
        skip_d = skip_q - 4'd1;
        if (skip_d == 4'd0) begin
          emit = 1'b1;
          res.instr_length = nb;
          res.opcode_offset = pcount_q;
        end
      end
      default: begin
        if (is_prefix(b)) begin
          if (b == PFX_OPS) osz_d = 1'b1;
          if (b == PFX_ADR) asz_d = 1'b1;
          pcount_d = pc;
          if (32'(pc) > 32'(MAX_PREFIXES)) begin
            emit = 1'b1;
            res.prefix_overflow = 1'b1;
            phase_d = PH_START;
            pcount_d = '0;
            osz_d = 1'b0;
            asz_d = 1'b0;
            popc_d = '0;
            flags_d = '0;
            mmode_d = '0;
            nbytes_d = '0;
            skip_d = '0;
          end
        end else begin
          popc_d = b;
          if (b == OP_ESC) begin
            phase_d = PH_EXT;
          end else begin
            flags_d = one_byte_flags(b);
            if (b >= 8'hA0 && b <= 8'hA3) osz_d = asz_q;
            if ((flags_d & FX) != 0) phase_d = PH_FPU;
            else if ((flags_d & FM) != 0) phase_d = PH_MODRM;
            else do_tail = 1'b1;
          end
        end
      end
    endcase
    // immediate size from the updated flags and operand size
    if ((flags_d & FB) != 0) imm = imm + 4'd1;
    if ((flags_d & FW) != 0) imm = imm + 4'd2;
    if ((flags_d & FP) != 0) imm = imm + (osz_d ? 4'd2 : 4'd4);
    tl = disp + imm;
    if (do_tail) begin
      if (tl == 4'd0) begin
        emit = 1'b1;
        res.instr_length = nb;
        res.opcode_offset = pcount_q;
      end else begin
        skip_d = tl;
        phase_d = PH_SKIP;
      end
    end
    if (emit && !res.prefix_overflow) begin
      phase_d = PH_START;
      pcount_d = '0;
      osz_d = 1'b0;
      asz_d = 1'b0;
      popc_d = '0;
      flags_d = '0;
      mmode_d = '0;
      nbytes_d = '0;
      skip_d = '0;
    end
  end

  // decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      pcount_q <= '0;
      osz_q <= 1'b0;
      asz_q <= 1'b0;
      popc_q <= '0;
      flags_q <= '0;
      mmode_q <= '0;
      nbytes_q <= '0;
      skip_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      pcount_q <= pcount_d;
      osz_q <= osz_d;
      asz_q <= asz_d;
      popc_q <= popc_d;
      flags_q <= flags_d;
      mmode_q <= mmode_d;
      nbytes_q <= nbytes_d;
      skip_q <= skip_d;
    end
  end

  // result word and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (!ov_q || out_o.ready) begin
        if (sv_q) begin
          ov_q <= 1'b1;
          sv_q <= 1'b0;
        end else begin
          ov_q <= fire && emit;
        end
      end else if (fire && emit) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_o.ready) begin
      od_q <= sv_q ? sd_q : res;
    end else if (fire && emit) begin
      sd_q <= res;
    end
  end

endmodule

@@ src/xild_checker.sv @@
module xild_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input xild_pkg::out_word_t out_data_i
);
  import xild_pkg::*;

  // overflow words carry no length
  a_ovf_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.prefix_overflow |-> out_data_i.instr_length == 5'd0)
    else $error("overflow word with nonzero length");

  // a normal word is at least one byte past its prefixes
  a_len_gt_ofs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.prefix_overflow |->
      out_data_i.instr_length > out_data_i.opcode_offset)
    else $error("length not beyond opcode offset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled word changed");

  // input only stalls while an output word is held
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

endmodule

bind x86_instruction_length_decoder xild_props u_xild_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

@@ dv/xild_checker.sv @@
`timescale 1ns / 1ps
module xild_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  xild_pkg::out_word_t out_word_i,
  output int          fail_count_o,
  output int          pending_o
);
  import xild_pkg::*;

  localparam int PREFIX_LIMIT = 16;

  typedef enum logic [2:0] {
    ST_START, ST_EXT, ST_FPU, ST_MODRM, ST_SIB, ST_SKIP
  } step_e;

  // flag tables, filled a row of sixteen at a time, one string per cell
  logic [7:0] one_tbl [256];
  logic [7:0] two_tbl [256];

  // decoder shadow state
  step_e      st;
  logic [4:0] pfx_n;
  logic       opsz, adsz;
  logic [7:0] prim_op, flags;
  logic [1:0] mod_keep;
  logic [4:0] len_acc;
  logic [3:0] skip_n;

  out_word_t length_q[$];

  function automatic logic [7:0] fl(input string s);
    logic [7:0] f;
    f = 0;
    for (int i = 0; i < s.len(); i++) begin
      case (s[i])
        "M": f |= FM;
        "B": f |= FB;
        "W": f |= FW;
        "P": f |= FP;
        "X": f |= FX;
        default: ;
      endcase
    end
    return f;
  endfunction

  task automatic fill_row(ref logic [7:0] t [256], input int row, input string cells[16]);
    for (int c = 0; c < 16; c++) t[row*16+c] = fl(cells[c]);
  endtask

  initial begin
    string a[16];
    for (int r = 0; r < 4; r++) begin
      a = '{"M","M","M","M","B","P","","","M","M","M","M","B","P","",""};
      fill_row(one_tbl, r, a);
    end
    a = '{default:""}; fill_row(one_tbl, 4, a); fill_row(one_tbl, 5, a);
    a = '{"","","M","M","","","","","P","MP","B","MB","","","",""}; fill_row(one_tbl, 6, a);
    a = '{default:"B"}; fill_row(one_tbl, 7, a);
    a = '{"MB","MP","MB","MB","M","M","M","M","M","M","M","M","M","M","M","M"};
    fill_row(one_tbl, 8, a);
    a = '{"","","","","","","","","","","WP","","","","",""}; fill_row(one_tbl, 9, a);
    a = '{"P","P","P","P","","","","","B","P","","","","","",""}; fill_row(one_tbl, 10, a);
    a = '{"B","B","B","B","B","B","B","B","P","P","P","P","P","P","P","P"};
    fill_row(one_tbl, 11, a);
    a = '{"MB","MB","W","","M","M","MB","MP","BW","","W","","","B","",""};
    fill_row(one_tbl, 12, a);
    a = '{"M","M","M","M","B","B","","","X","X","X","X","X","X","X","X"};
    fill_row(one_tbl, 13, a);
    a = '{"B","B","B","B","B","B","B","B","P","P","WP","B","","","",""};
    fill_row(one_tbl, 14, a);
    a = '{"","","","","","","M","M","","","","","","","M","M"}; fill_row(one_tbl, 15, a);

    a = '{"M","M","M","M","","","","","","","","","","M","","MB"}; fill_row(two_tbl, 0, a);
    a = '{"M","M","M","M","M","M","M","M","M","","","","","","",""}; fill_row(two_tbl, 1, a);
    a = '{"M","M","M","M","M","","M","","M","M","M","M","M","M","M","M"};
    fill_row(two_tbl, 2, a);
    a = '{default:""}; fill_row(two_tbl, 3, a);
    a = '{default:"M"};
    fill_row(two_tbl, 4, a); fill_row(two_tbl, 5, a); fill_row(two_tbl, 6, a);
    fill_row(two_tbl, 9, a); fill_row(two_tbl, 13, a); fill_row(two_tbl, 14, a);
    a = '{"MB","MB","MB","MB","M","M","M","","","","","","M","M","M","M"};
    fill_row(two_tbl, 7, a);
    a = '{default:"P"}; fill_row(two_tbl, 8, a);
    a = '{"","","","M","MB","M","","","","","","M","MB","M","M","M"}; fill_row(two_tbl, 10, a);
    a = '{"M","M","M","M","M","M","M","M","","","MB","M","M","M","M","M"};
    fill_row(two_tbl, 11, a);
    a = '{"M","M","MB","M","MB","MB","MB","M","","","","","","","",""};
    fill_row(two_tbl, 12, a);
    a = '{"M","M","M","M","M","M","M","M","M","M","M","M","M","M","M",""};
    fill_row(two_tbl, 15, a);
  end

  function automatic logic is_pfx(input logic [7:0] b);
    return b inside {8'h2E, 8'h3E, 8'h36, 8'h26, 8'h64, 8'h65,
                     8'hF0, 8'hF2, 8'hF3, PFX_OPS, PFX_ADR};
  endfunction

  function automatic int imm_bytes();
    int n;
    n = 0;
    if (flags & FB) n += 1;
    if (flags & FW) n += 2;
    if (flags & FP) n += opsz ? 2 : 4;
    return n;
  endfunction

  task automatic clear_shadow();
    st = ST_START; pfx_n = 0; opsz = 0; adsz = 0; prim_op = 0;
    flags = 0; mod_keep = 0; len_acc = 0; skip_n = 0;
  endtask

  task automatic emit_length();
    out_word_t w;
    w.instr_length = len_acc;
    w.opcode_offset = pfx_n;
    w.prefix_overflow = 1'b0;
    length_q.push_back(w);
    clear_shadow();
  endtask

  task automatic go_tail(input int n);
    if (n == 0) emit_length();
    else begin
      skip_n = n[3:0];
      st = ST_SKIP;
    end
  endtask

  task automatic go_after_opcode();
    if (flags & FX) st = ST_FPU;
    else if (flags & FM) st = ST_MODRM;
    else go_tail(imm_bytes());
  endtask

  // advance the shadow decoder by one accepted code byte
  task automatic decode_byte(input logic [7:0] b);
    logic [1:0] md;
    logic [2:0] rg, rm;
    int dsp;
    out_word_t w;
    len_acc = len_acc + 5'd1;
    md = b[7:6]; rg = b[5:3]; rm = b[2:0];
    case (st)
      ST_EXT: begin
        flags = two_tbl[b];
        go_after_opcode();
      end
      ST_FPU: begin
        if (flags & FM) st = ST_MODRM;
        else go_tail(imm_bytes());
      end
      ST_MODRM: begin
        if (prim_op == OP_F6 && rg == 0) flags |= FB;
        if (prim_op == OP_F7 && rg == 0) flags |= FP;
        dsp = 0;
        if (md == 0) begin
          if (adsz && rm == 6) dsp = 2;
          if (!adsz && rm == 5) dsp = 4;
        end else if (md == 1) dsp = 1;
        else if (md == 2) dsp = adsz ? 2 : 4;
        if (md != 3 && !adsz && rm == 4) begin
          mod_keep = md;
          st = ST_SIB;
        end else go_tail(dsp + imm_bytes());
      end
      ST_SIB: begin
        if (mod_keep == 1) dsp = 1;
        else if (mod_keep == 2) dsp = 4;
        else dsp = (rm == 5) ? 4 : 0;
        go_tail(dsp + imm_bytes());
      end
      ST_SKIP: begin
        skip_n = skip_n - 4'd1;
        if (skip_n == 0) emit_length();
      end
      default: begin
        if (is_pfx(b)) begin
          if (b == PFX_OPS) opsz = 1;
          if (b == PFX_ADR) adsz = 1;
          pfx_n = pfx_n + 5'd1;
          if (pfx_n > PREFIX_LIMIT) begin
            w.instr_length = 0; w.opcode_offset = 0; w.prefix_overflow = 1;
            length_q.push_back(w);
            clear_shadow();
          end
        end else begin
          prim_op = b;
          if (b == OP_ESC) st = ST_EXT;
          else begin
            flags = one_tbl[b];
            if (b >= 8'hA0 && b <= 8'hA3) opsz = adsz;
            go_after_opcode();
          end
        end
      end
    endcase
  endtask

  // watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      clear_shadow();
      length_q.delete();
      pending_o = 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (length_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected word: len=%0d off=%0d ovf=%0b", out_word_i.instr_length,
                     out_word_i.opcode_offset, out_word_i.prefix_overflow);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = length_q.pop_front();
          if (exp_w !== out_word_i) begin
            if (fail_count_o < 10)
              $display("mismatch: exp len=%0d off=%0d ovf=%0b, got len=%0d off=%0d ovf=%0b",
                       exp_w.instr_length, exp_w.opcode_offset, exp_w.prefix_overflow,
                       out_word_i.instr_length, out_word_i.opcode_offset,
                       out_word_i.prefix_overflow);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i);
      pending_o = length_q.size();
    end
  end
endmodule

@@ dv/tb_x86_instruction_length_decoder.sv @@
`timescale 1ns / 1ps
module tb_x86_instruction_length_decoder;
  import xild_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   feed_done;

  xild_in_if  in_ch ();
  xild_out_if out_ch ();

  x86_instruction_length_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  xild_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_byte_i    (in_ch.data.code_byte),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_word_i   (out_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // send one code byte, waiting for acceptance
  task automatic send_byte(input logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.code_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] any_prefix();
    logic [7:0] p[11] = '{8'h2E, 8'h3E, 8'h36, 8'h26, 8'h64, 8'h65,
                          8'hF0, 8'hF2, 8'hF3, 8'h66, 8'h67};
    return p[$urandom_range(0, 10)];
  endfunction

  // well-formed-ish instruction: prefixes, opcode, then random tail bytes
  task automatic send_instr();
    int np;
    logic [7:0] op;
    np = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 4);
    repeat (np) send_byte(($urandom_range(0, 1)) ? any_prefix()
                                                 : (($urandom_range(0, 1)) ? 8'h66 : 8'h67));
    case ($urandom_range(0, 5))
      0: op = 8'h0F;
      1: op = 8'(8'hF6 + $urandom_range(0, 1));
      2: op = 8'(8'hA0 + $urandom_range(0, 3));
      3: op = 8'(8'hD8 + $urandom_range(0, 7));
      default: op = 8'($urandom_range(0, 255));
    endcase
    send_byte(op);
    // tail bytes; the decoder finds the boundary itself
    repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // sink side: random stalls
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
  end

  initial begin
    logic [7:0] dir[$];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    feed_done = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: simple, escape, modrm/sib, f6/f7, moffs, fpu, extremes
    dir = '{8'h90, 8'h00, 8'hC0, 8'h0F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h8B, 8'h04, 8'h25, 8'h11, 8'h22, 8'h33, 8'h44,
            8'hF6, 8'h00, 8'h7F, 8'hF7, 8'h08,
            8'h66, 8'hA1, 8'h12, 8'h34, 8'hDF, 8'hFF, 8'h67, 8'h8B, 8'h86, 8'h01, 8'h02};
    foreach (dir[i]) send_byte(dir[i]);
    wait_drain();
    // prefix overflow: seventeen prefixes, then a lone opcode; then sixteen prefixes and a nop
    repeat (17) send_byte(8'hF3);
    send_byte(8'hC3);
    repeat (16) send_byte(8'h2E);
    send_byte(8'h90);
    wait_drain();

    // random part, mostly instruction shapes with some raw noise
    for (int n = 0; n < 165; n++) begin
      if ($urandom_range(0, 9) < 8) send_instr();
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      if (n == 80) wait_drain();
    end
    // finish the instruction in flight with single-byte opcodes
    repeat (20) send_byte(8'h90);
    wait_drain();
    feed_done = 1;
  end

  initial begin
    wait (feed_done);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
src/xild_pkg.sv
src/xild_if.sv
src/x86_instruction_length_decoder.sv
src/xild_checker.sv
dv/xild_checker.sv
dv/tb_x86_instruction_length_decoder.sv
